>>> hw/rtl/integer_literal_list_recognizer_assert.svh
// Assertion macros used by the recognizer RTL (included by ilr_dfa).
`ifndef INTEGER_LITERAL_LIST_RECOGNIZER_ASSERT_SVH
`define INTEGER_LITERAL_LIST_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ILR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ilr_pkg.sv
package ilr_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned VerdictW = 2;
  localparam int unsigned StateW   = 4;

  typedef enum logic [StateW-1:0] {
    ST_START    = 4'd0,
    ST_MINUS    = 4'd1,
    ST_DEC      = 4'd2,
    ST_ZERO     = 4'd3,
    ST_HEX_PFX  = 4'd4,
    ST_HEX      = 4'd5,
    ST_OCT_PFX  = 4'd6,
    ST_OCT      = 4'd7,
    ST_DEAD     = 4'd8
  } ilr_state_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_IN      = 2'd0,
    VERDICT_OUT     = 2'd1,
    VERDICT_FOREIGN = 2'd2
  } ilr_verdict_e;

  // Character classes; bytes that share every transition share a class.
  typedef enum logic [3:0] {
    CLS_MINUS,
    CLS_ZERO,
    CLS_OCT_DIGIT,  // '1'..'7'
    CLS_DEC_DIGIT,  // '8','9'
    CLS_X,          // 'x','X'
    CLS_HEX_LETTER, // 'a'..'f','A'..'F'
    CLS_O,          // 'o','O'
    CLS_HASH,
    CLS_FOREIGN
  } ilr_class_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             first;
  } ilr_item_t;

  // Input register contents handed to the recognizer stage.
  typedef struct packed {
    logic      valid;
    ilr_item_t item;
  } ilr_stage_t;

  typedef struct packed {
    logic                valid;
    logic [VerdictW-1:0] verdict;
    logic [StateW-1:0]   dfa_state;
  } ilr_result_t;

  function automatic ilr_class_e char_class(input logic [CharW-1:0] b);
    ilr_class_e c;
    c = CLS_FOREIGN;
    if (b == CharW'("-"))                                c = CLS_MINUS;
    else if (b == CharW'("#"))                           c = CLS_HASH;
    else if (b == CharW'("x") || b == CharW'("X"))      c = CLS_X;
    else if (b == CharW'("o") || b == CharW'("O"))      c = CLS_O;
    else if (b == CharW'("0"))                           c = CLS_ZERO;
    else if (b >= CharW'("1") && b <= CharW'("7"))      c = CLS_OCT_DIGIT;
    else if (b == CharW'("8") || b == CharW'("9"))      c = CLS_DEC_DIGIT;
    else if ((b >= CharW'("a") && b <= CharW'("f")) ||
             (b >= CharW'("A") && b <= CharW'("F")))    c = CLS_HEX_LETTER;
    return c;
  endfunction

  function automatic ilr_state_e next_state(input ilr_state_e s, input ilr_class_e c);
    ilr_state_e n;
    logic digit;
    digit = (c == CLS_ZERO) || (c == CLS_OCT_DIGIT) || (c == CLS_DEC_DIGIT);
    n = ST_DEAD;
    unique case (s)
      ST_START: begin
        if (c == CLS_MINUS)     n = ST_MINUS;
        else if (c == CLS_ZERO) n = ST_ZERO;
        else if (digit)         n = ST_DEC;
      end
      ST_MINUS: begin
        if (digit && c != CLS_ZERO) n = ST_DEC;
      end
      ST_DEC: begin
        if (digit)              n = ST_DEC;
        else if (c == CLS_HASH) n = ST_START;
      end
      ST_ZERO: begin
        if (c == CLS_X)         n = ST_HEX_PFX;
        else if (c == CLS_O)    n = ST_OCT_PFX;
      end
      ST_HEX_PFX: begin
        if (digit || c == CLS_HEX_LETTER) n = ST_HEX;
      end
      ST_HEX: begin
        if (digit || c == CLS_HEX_LETTER) n = ST_HEX;
        else if (c == CLS_HASH)           n = ST_START;
      end
      ST_OCT_PFX: begin
        if (c == CLS_ZERO || c == CLS_OCT_DIGIT) n = ST_OCT;
      end
      ST_OCT: begin
        if (c == CLS_ZERO || c == CLS_OCT_DIGIT) n = ST_OCT;
        else if (c == CLS_HASH)                  n = ST_START;
      end
      default: n = ST_DEAD;
    endcase
    return n;
  endfunction

  function automatic logic is_accepting(input ilr_state_e s);
    return (s == ST_DEC) || (s == ST_HEX) || (s == ST_OCT);
  endfunction

endpackage

>>> hw/rtl/ilr_if.sv
interface ilr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       first;

  modport source (output valid, output char_code, output first, input ready);
  modport sink   (input valid, input char_code, input first, output ready);
endinterface

interface ilr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [3:0] dfa_state;

  modport source (output valid, output verdict, output dfa_state, input ready);
  modport sink   (input valid, input verdict, input dfa_state, output ready);
endinterface

>>> hw/rtl/integer_literal_list_recognizer.sv
// Channel   Dir  Payload                         Accept
// char_i    in   char_code[7:0], first           valid && ready
// result_o  out  verdict[1:0], dfa_state[3:0]    valid && ready
//
// One item per cycle sustained while results are taken. A byte held in the input
// register moves into the result register when the result slot is free or drained.
// The update (class, transition, verdict) is combinational between the two.
// Reset (rst_ni low, asynchronous) empties both registers, returns the
// recognizer to the start state and clears the foreign flag.
// A stalled result holds its register; char_i drops ready only when both are full.
module integer_literal_list_recognizer (
  input  logic clk_i,
  input  logic rst_ni,
  ilr_char_if.sink     char_i,
  ilr_result_if.source result_o
);
  import ilr_pkg::*;

  ilr_item_t   in_item;
  ilr_stage_t  stage;
  ilr_result_t result;
  logic        advance;

  assign in_item = '{char_code: char_i.char_code, first: char_i.first};

  // Input register: holds one byte until the recognizer takes it.
  ilr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (char_i.valid),
    .ready_o   (char_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // Recognizer: state update and result register; advance when the result
  // slot is free or being drained.
  ilr_dfa u_dfa (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_ready_i (result_o.ready),
    .result_o    (result)
  );

  assign result_o.valid     = result.valid;
  assign result_o.verdict   = result.verdict;
  assign result_o.dfa_state = result.dfa_state;

endmodule

>>> hw/rtl/ilr_in_reg.sv
module ilr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ilr_pkg::ilr_item_t item_i,
  input  logic               advance_i,
  output ilr_pkg::ilr_stage_t stage_o
);
  import ilr_pkg::*;

  logic      valid_q;
  ilr_item_t item_q;

  // Take a new item when empty or when the held one moves on this cycle.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign stage_o = '{valid: valid_q, item: item_q};

endmodule

>>> hw/rtl/ilr_dfa.sv
module ilr_dfa (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ilr_pkg::ilr_stage_t  stage_i,
  output logic                 advance_o,
  input  logic                 out_ready_i,
  output ilr_pkg::ilr_result_t result_o
);
  import ilr_pkg::*;

  ilr_state_e state_q, state_d, base_state;
  logic       foreign_q, foreign_d;
  ilr_class_e cls;

  logic         out_valid_q;
  ilr_verdict_e verdict_q, verdict_d;
  ilr_state_e   out_state_q;

  assign advance_o = stage_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    cls        = char_class(stage_i.item.char_code);
    base_state = stage_i.item.first ? ST_START : state_q;
    foreign_d  = (!stage_i.item.first && foreign_q) || (cls == CLS_FOREIGN);
    state_d    = (cls == CLS_FOREIGN) ? ST_DEAD : next_state(base_state, cls);
    if (foreign_d) begin
      verdict_d = VERDICT_FOREIGN;
    end else if (is_accepting(state_d)) begin
      verdict_d = VERDICT_IN;
    end else begin
      verdict_d = VERDICT_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      foreign_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        state_q   <= state_d;
        foreign_q <= foreign_d;
      end
      if (advance_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      verdict_q   <= verdict_d;
      out_state_q <= state_d;
    end
  end

  assign result_o = '{valid: out_valid_q, verdict: verdict_q, dfa_state: out_state_q};

`include "integer_literal_list_recognizer_assert.svh"

  `ILR_ASSERT_IMP(a_in_means_accepting, out_valid_q && verdict_q == VERDICT_IN,
                  out_state_q == ST_DEC || out_state_q == ST_HEX || out_state_q == ST_OCT,
                  "in-language verdict without an accepting state")
  `ILR_ASSERT_IMP(a_foreign_means_dead, out_valid_q && verdict_q == VERDICT_FOREIGN,
                  out_state_q == ST_DEAD && foreign_q,
                  "foreign verdict while recognizer is not dead")
  `ILR_ASSERT_NXT(a_foreign_char_flags, advance_o && cls == CLS_FOREIGN,
                  out_valid_q && verdict_q == VERDICT_FOREIGN,
                  "foreign byte did not yield a foreign verdict")
  `ILR_ASSERT_NXT(a_state_tracks_output, advance_o,
                  state_q == out_state_q,
                  "stored state and reported state disagree")

endmodule

>>> tb/integer_literal_list_recognizer_tb.sv
`timescale 1ns / 1ps

module integer_literal_list_recognizer_tb;
  import ilr_pkg::*;

  localparam int unsigned LimitCycles  = 200000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PhaseItems   = 600;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned MaxErrLines  = 100;

  // One expected result: verdict for the string so far and the state reached.
  typedef struct packed {
    ilr_verdict_e verdict;
    ilr_state_e   state;
  } lex_result_t;

  // Directed probe row. The verdict and state columns are only trusted
  // where pinned is set; elsewhere the scanner below supplies the answer.
  typedef struct {
    logic [7:0]   code;
    logic         first;
    bit           pinned;
    ilr_verdict_e verdict;
    ilr_state_e   state;
  } probe_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ilr_char_if   char_if ();
  ilr_result_if result_if ();

  integer_literal_list_recognizer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .result_o(result_if)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scanner state, kept apart from the block.
  ilr_state_e  lex_state = ST_START;
  bit          lex_foreign = 1'b0;

  // Results owed by the block, oldest first.
  lex_result_t verdicts_due[$];

  // Bytes of the string being sent.
  logic [7:0]  text_q[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent; the stimulus process sets them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long result hold-offs: the stimulus bumps requests, the sink serves them.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  // Directed probes: separators, restarts, every literal form, dead paths,
  // and the byte extremes 0x00 and 0xFF as foreign bytes.
  probe_row_t probes [0:24] = '{
    '{"0",   1'b1, 1'b1, VERDICT_OUT,     ST_ZERO},
    '{"x",   1'b0, 1'b0, VERDICT_OUT,     ST_HEX_PFX},
    '{"F",   1'b0, 1'b1, VERDICT_IN,      ST_HEX},
    '{"a",   1'b0, 1'b0, VERDICT_IN,      ST_HEX},
    // trailing separator drops back to start, not accepting
    '{"#",   1'b0, 1'b1, VERDICT_OUT,     ST_START},
    '{"0",   1'b0, 1'b0, VERDICT_OUT,     ST_ZERO},
    '{"O",   1'b0, 1'b0, VERDICT_OUT,     ST_OCT_PFX},
    '{"7",   1'b0, 1'b1, VERDICT_IN,      ST_OCT},
    '{"#",   1'b0, 1'b0, VERDICT_OUT,     ST_START},
    '{"-",   1'b0, 1'b0, VERDICT_OUT,     ST_MINUS},
    '{"9",   1'b0, 1'b0, VERDICT_IN,      ST_DEC},
    '{"8",   1'b0, 1'b0, VERDICT_IN,      ST_DEC},
    '{"#",   1'b0, 1'b0, VERDICT_OUT,     ST_START},
    '{"0",   1'b0, 1'b0, VERDICT_OUT,     ST_ZERO},
    '{"o",   1'b0, 1'b0, VERDICT_OUT,     ST_OCT_PFX},
    '{"0",   1'b0, 1'b0, VERDICT_IN,      ST_OCT},
    // '8' is not an octal digit
    '{"8",   1'b0, 1'b1, VERDICT_OUT,     ST_DEAD},
    '{"1",   1'b1, 1'b0, VERDICT_IN,      ST_DEC},
    // NUL is foreign and the flag sticks until a restart
    '{8'h00, 1'b0, 1'b1, VERDICT_FOREIGN, ST_DEAD},
    '{"1",   1'b0, 1'b1, VERDICT_FOREIGN, ST_DEAD},
    '{8'hFF, 1'b1, 1'b1, VERDICT_FOREIGN, ST_DEAD},
    '{"-",   1'b1, 1'b0, VERDICT_OUT,     ST_MINUS},
    // no "-0"
    '{"0",   1'b0, 1'b0, VERDICT_OUT,     ST_DEAD},
    '{"X",   1'b1, 1'b1, VERDICT_OUT,     ST_DEAD},
    '{"7",   1'b1, 1'b0, VERDICT_IN,      ST_DEC}
  };

  // Advance the scanner by one byte and return what the block must report.
  function automatic lex_result_t scan_char(input logic [7:0] b, input logic restart);
    lex_result_t res;
    ilr_state_e  nxt;
    logic        is_dig, is_nz, is_oct, is_hexl, is_x, is_o, is_hash, is_minus;
    is_dig   = (b >= "0") && (b <= "9");
    is_nz    = is_dig && (b != "0");
    is_oct   = (b >= "0") && (b <= "7");
    is_hexl  = ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
    is_x     = (b == "x") || (b == "X");
    is_o     = (b == "o") || (b == "O");
    is_hash  = (b == "#");
    is_minus = (b == "-");
    if (restart) begin
      lex_state   = ST_START;
      lex_foreign = 1'b0;
    end
    nxt = ST_DEAD;
    if (!(is_dig || is_hexl || is_x || is_o || is_hash || is_minus)) begin
      lex_foreign = 1'b1;
    end else begin
      case (lex_state)
        ST_START: begin
          if (is_minus)      nxt = ST_MINUS;
          else if (b == "0") nxt = ST_ZERO;
          else if (is_nz)    nxt = ST_DEC;
        end
        ST_MINUS: begin
          if (is_nz) nxt = ST_DEC;
        end
        ST_DEC: begin
          if (is_dig)       nxt = ST_DEC;
          else if (is_hash) nxt = ST_START;
        end
        ST_ZERO: begin
          if (is_x)      nxt = ST_HEX_PFX;
          else if (is_o) nxt = ST_OCT_PFX;
        end
        ST_HEX_PFX: begin
          if (is_dig || is_hexl) nxt = ST_HEX;
        end
        ST_HEX: begin
          if (is_dig || is_hexl) nxt = ST_HEX;
          else if (is_hash)      nxt = ST_START;
        end
        ST_OCT_PFX: begin
          if (is_oct) nxt = ST_OCT;
        end
        ST_OCT: begin
          if (is_oct)       nxt = ST_OCT;
          else if (is_hash) nxt = ST_START;
        end
        default: nxt = ST_DEAD;
      endcase
    end
    lex_state = nxt;
    if (lex_foreign) begin
      res.verdict = VERDICT_FOREIGN;
    end else if (nxt == ST_DEC || nxt == ST_HEX || nxt == ST_OCT) begin
      res.verdict = VERDICT_IN;
    end else begin
      res.verdict = VERDICT_OUT;
    end
    res.state = nxt;
    return res;
  endfunction

  task automatic flag_error(input string field, input logic [3:0] got, input logic [3:0] want);
    if (error_count < MaxErrLines) begin
      $display("ERROR %s mismatch at cycle %0d: got %0d, want %0d",
               field, cycle_count, got, want);
    end
    error_count++;
  endtask

  // Offer one byte, hold it until taken, then log what it must produce.
  // A pinned row logs its typed answer but still steps the scanner.
  task automatic send_char(input logic [7:0] code, input logic first, input bit pinned,
                           input lex_result_t pinned_want);
    lex_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= code;
    char_if.first     <= first;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    want = scan_char(code, first);
    verdicts_due.push_back(pinned ? pinned_want : want);
  endtask

  // Drop valid and wait until the block has returned everything.
  task automatic wait_drained();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // Any byte of the alphabet, each byte with equal chance.
  function automatic logic [7:0] pick_alpha();
    int unsigned r;
    r = $urandom_range(0, 27);
    if (r == 0)       return "-";
    else if (r <= 10) return "0" + 8'(r - 1);
    else if (r == 11) return "x";
    else if (r == 12) return "X";
    else if (r <= 18) return "a" + 8'(r - 13);
    else if (r <= 24) return "A" + 8'(r - 19);
    else if (r == 25) return "o";
    else if (r == 26) return "O";
    return "#";
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10)      return "0" + 8'(r);
    else if (r < 16) return "a" + 8'(r - 10);
    return "A" + 8'(r - 16);
  endfunction

  // Append one well-formed literal of a random form.
  function automatic void add_literal();
    int unsigned n;
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1)) text_q.push_back("-");
        text_q.push_back("1" + 8'($urandom_range(0, 8)));
        n = $urandom_range(0, 4);
        repeat (n) text_q.push_back("0" + 8'($urandom_range(0, 9)));
      end
      1: begin
        text_q.push_back("0");
        text_q.push_back($urandom_range(0, 1) ? "x" : "X");
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back(pick_hex());
      end
      2: begin
        text_q.push_back("0");
        text_q.push_back($urandom_range(0, 1) ? "o" : "O");
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back("0" + 8'($urandom_range(0, 7)));
      end
      default: text_q.push_back("0");
    endcase
  endfunction

  // Build the next string: mostly '#'-joined literal lists, some with a
  // trailing separator or one corrupted byte, the rest plain noise.
  function automatic void build_text();
    int unsigned n, pos;
    text_q.delete();
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        text_q.push_back($urandom_range(0, 1) ? pick_alpha() : 8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int unsigned k = 0; k < n; k++) begin
        if (k != 0) text_q.push_back("#");
        add_literal();
      end
      if ($urandom_range(0, 99) < 15) text_q.push_back("#");
      if ($urandom_range(0, 99) < 20) begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = $urandom_range(0, 1) ? pick_alpha() : 8'($urandom_range(0, 255));
      end
    end
  endfunction

  // Result sink: random ready, plus long hold-offs on request.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LongHold - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk_i) begin
    lex_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (verdicts_due.size() == 0) begin
        flag_error("unexpected result, state", result_if.dfa_state, 4'd0);
      end else begin
        want = verdicts_due.pop_front();
        if (result_if.verdict !== want.verdict) begin
          flag_error("verdict", {2'b00, result_if.verdict}, {2'b00, want.verdict});
        end
        if (result_if.dfa_state !== want.state) begin
          flag_error("dfa_state", result_if.dfa_state, want.state);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("FAIL integer_literal_list_recognizer");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    lex_result_t pin;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    char_if.first     = 1'b0;

    // Hold reset low, then release it on a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed probes with moderate idling on both sides.
    send_idle_pct = 10;
    recv_idle_pct = 30;
    foreach (probes[i]) begin
      pin = '{verdict: probes[i].verdict, state: probes[i].state};
      send_char(probes[i].code, probes[i].first, probes[i].pinned, pin);
    end
    // Pause the sender until every result is back.
    wait_drained();

    // Random phases: slow receiver, then slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Stall results for a long stretch while bytes keep coming,
          // so both registers fill and char_i drops ready.
          hold_requests++;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        build_text();
        foreach (text_q[k]) send_char(text_q[k], k == 0, 1'b0, '0);
        sent += text_q.size();
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS integer_literal_list_recognizer");
    end else begin
      $display("FAIL integer_literal_list_recognizer");
    end
    $finish;
  end

endmodule
